// ===== rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types, codes and the microprogram of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int KEY_W     = 31;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 4;
  localparam int BCNT_W    = 2;   // counts the remainder stages down
  localparam int STEP_W    = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } stat_e;

  // microprogram addresses
  typedef enum logic [STEP_W-1:0] {
    S_CLR  = 3'd0,
    S_IDLE = 3'd1,
    S_DIV  = 3'd2,
    S_HOME = 3'd3,
    S_READ = 3'd4,
    S_EVAL = 3'd5,
    S_FIN  = 3'd6
  } step_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_CLR  = 3'd1,
    OP_LOAD = 3'd2,
    OP_DIV  = 3'd3,
    OP_HOME = 3'd4,
    OP_EVAL = 3'd5,
    OP_FIN  = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_CLR_MORE  = 3'd1,
    C_NO_ACCEPT = 3'd2,
    C_DIV_MORE  = 3'd3,
    C_NOT_DONE  = 3'd4,
    C_OUT_BUSY  = 3'd5
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e tgt_t;   // taken when the condition holds
    step_e tgt_f;
  } ctrl_word_t;

  typedef struct packed {
    logic no_accept;
    logic clr_more;
    logic div_more;
    logic not_done;
    logic out_busy;
  } flags_t;

  function automatic ctrl_word_t lph_ucode(input step_e step);
    ctrl_word_t w;
    case (step)
      S_CLR:   w = '{OP_CLR,  C_CLR_MORE,  S_CLR,  S_IDLE};
      S_IDLE:  w = '{OP_LOAD, C_NO_ACCEPT, S_IDLE, S_DIV};
      S_DIV:   w = '{OP_DIV,  C_DIV_MORE,  S_DIV,  S_HOME};
      S_HOME:  w = '{OP_HOME, C_ALWAYS,    S_READ, S_READ};
      S_READ:  w = '{OP_NONE, C_ALWAYS,    S_EVAL, S_EVAL};
      S_EVAL:  w = '{OP_EVAL, C_NOT_DONE,  S_READ, S_FIN};
      S_FIN:   w = '{OP_FIN,  C_OUT_BUSY,  S_FIN,  S_IDLE};
      default: w = '{OP_NONE, C_ALWAYS,    S_IDLE, S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/lph_sequencer.sv =====
// ----------------------------------------------------------------------------
// lph_sequencer
// Step counter over the microprogram ROM with conditional two-way jumps.
// ----------------------------------------------------------------------------
module lph_sequencer import lph_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  flags_t     flags_i,
  output ctrl_word_t ctrl_o
);

  step_e      step_q, step_d;
  ctrl_word_t word;
  logic       take;

  assign word   = lph_ucode(step_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      C_ALWAYS:    take = 1'b1;
      C_CLR_MORE:  take = flags_i.clr_more;
      C_NO_ACCEPT: take = flags_i.no_accept;
      C_DIV_MORE:  take = flags_i.div_more;
      C_NOT_DONE:  take = flags_i.not_done;
      C_OUT_BUSY:  take = flags_i.out_busy;
      default:     take = 1'b1;
    endcase
    step_d = take ? word.tgt_t : word.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_CLR;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/lph_datapath.sv =====
// ----------------------------------------------------------------------------
// lph_datapath
// Key/valid memory, home-slot remainder unit, probe counter and result register.
// ----------------------------------------------------------------------------
module lph_datapath import lph_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_word_t  ctrl_i,
  output flags_t      flags_o,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [30:0] key
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [3:0] slot
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  localparam int  SW        = $clog2(SLOTS);
  localparam int  MW        = KEY_W + 1;     // valid bit above the key
  localparam int  PW        = KEY_W + 32;    // key times reciprocal
  localparam int  DIV_STEPS = 4;
  localparam bit  POW2      = (SLOTS & (SLOTS - 1)) == 0;
  // floor(key / SLOTS) == (key * RECIP) >> (KEY_W + SW) for every 31-bit key
  localparam logic [31:0] RECIP =
    32'(((64'd1 << (KEY_W + SW)) / 64'(SLOTS)) + 64'd1);

  logic [MW-1:0]     slot_mem_q [SLOTS];
  logic [MW-1:0]     rd_q;

  req_e              req_q;
  logic [KEY_W-1:0]  key_q;
  logic [BCNT_W-1:0] bcnt_q;
  logic [PW-1:0]     prod_q;
  logic [KEY_W-1:0]  quot_q;
  logic [KEY_W-1:0]  qs_q;
  logic [SW-1:0]     rem_q;
  logic [SW-1:0]     idx_q;
  logic [SW-1:0]     pcnt_q;
  stat_e             res_status_q;
  logic              res_wr_q;
  logic              res_wv_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              out_valid_q;
  stat_e             out_status_q;
  logic [SLOT_W-1:0] out_slot_q;

  logic              accept;
  logic              out_free;
  logic              fin_go;
  logic              mem_we;
  logic [MW-1:0]     mem_wdata;
  logic [SW-1:0]     idx_nxt;
  logic [SW+3:0]     idx_wide;
  logic              ent_v;
  logic              ent_match;
  logic              last;
  logic              done;
  stat_e             ev_status;
  logic              ev_wr;
  logic              ev_wv;
  logic              ev_slot;

  assign s_axis_tready_o = (ctrl_i.op == OP_LOAD);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fin_go          = (ctrl_i.op == OP_FIN) && out_free;

  assign idx_nxt  = (idx_q == SW'(SLOTS - 1)) ? '0 : idx_q + SW'(1);
  assign idx_wide = {4'b0000, idx_q};

  assign ent_v     = rd_q[MW-1];
  assign ent_match = ent_v && (rd_q[KEY_W-1:0] == key_q);
  assign last      = (pcnt_q == SW'(SLOTS - 1));

  always_comb begin
    done    = 1'b0;
    ev_status = STAT_NOT_FOUND;
    ev_wr   = 1'b0;
    ev_wv   = 1'b0;
    ev_slot = 1'b0;
    case (req_q)
      REQ_INSERT: begin
        if (!ent_v) begin
          done = 1'b1; ev_status = STAT_INSERTED; ev_wr = 1'b1; ev_wv = 1'b1;
          ev_slot = 1'b1;
        end else if (last) begin
          done = 1'b1; ev_status = STAT_FULL;
        end
      end
      REQ_REMOVE: begin
        if (ent_match) begin
          done = 1'b1; ev_status = STAT_REMOVED; ev_wr = 1'b1; ev_slot = 1'b1;
        end else if (!ent_v || last) begin
          done = 1'b1;
        end
      end
      REQ_SEARCH: begin
        if (ent_match) begin
          done = 1'b1; ev_status = STAT_FOUND; ev_slot = 1'b1;
        end else if (!ent_v || last) begin
          done = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase
  end

  assign flags_o.no_accept = !accept;
  assign flags_o.clr_more  = (idx_q != SW'(SLOTS - 1));
  assign flags_o.div_more  = !POW2 && (bcnt_q != '0);
  assign flags_o.not_done  = !done;
  assign flags_o.out_busy  = !out_free;

  assign mem_we    = (ctrl_i.op == OP_CLR) || (fin_go && res_wr_q);
  assign mem_wdata = (ctrl_i.op == OP_CLR) ? '0 : {res_wv_q, key_q};

  // memory: one write port, one registered read at the probe index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[idx_q] <= mem_wdata;
    end
    rd_q <= slot_mem_q[idx_q];
  end

  // request and probe payload
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        if (accept) begin
          req_q  <= req_e'(s_axis_tuser_i);
          key_q  <= s_axis_tdata_i[KEY_W-1:0];
          bcnt_q <= BCNT_W'(DIV_STEPS - 1);
          rem_q  <= '0;
        end
      end
      OP_DIV: begin
        if (POW2) begin
          rem_q <= key_q[SW-1:0];
        end else begin
          // multiply by the reciprocal, shift, multiply back, subtract
          prod_q <= PW'(key_q) * PW'(RECIP);
          quot_q <= KEY_W'(prod_q >> (KEY_W + SW));
          qs_q   <= quot_q * KEY_W'(SLOTS);
          rem_q  <= SW'(key_q - qs_q);
          bcnt_q <= bcnt_q - BCNT_W'(1);
        end
      end
      OP_HOME: begin
        pcnt_q <= '0;
      end
      OP_EVAL: begin
        pcnt_q       <= pcnt_q + SW'(1);
        res_status_q <= ev_status;
        res_wr_q     <= ev_wr;
        res_wv_q     <= ev_wv;
        res_slot_q   <= ev_slot ? idx_wide[SLOT_W-1:0] : '0;
      end
      default: ;
    endcase
  end

  // probe index and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (ctrl_i.op)
        OP_CLR:  if (flags_o.clr_more) idx_q <= idx_nxt;
        OP_HOME: idx_q <= rem_q;
        OP_EVAL: if (!done) idx_q <= idx_nxt;
        default: ;
      endcase
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {4'b0000, out_slot_q};

  // the probe index never leaves the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= SW'(SLOTS - 1))
    else $error("probe index out of range");

  // the home slot handed to the probe walk is a proper remainder
  a_home_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_HOME) |-> (rem_q <= SW'(SLOTS - 1)))
    else $error("home slot out of range");

  // an accepted item always enters the remainder step next
  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (ctrl_i.op == OP_DIV))
    else $error("accepted item did not start the home-slot step");

  // a finished item shows up at the output in the following cycle
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (out_valid_q && (ctrl_i.op == OP_LOAD)))
    else $error("result not presented after finish step");

endmodule

// ===== rtl/linear_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory clean, one slot a cycle; no
// item is taken until that pass ends. Each item then runs through the
// microprogram: an accept step, the home-slot remainder (a reciprocal
// multiply, shift, multiply back and subtract, or the low key bits when SLOTS
// is a power of two), a step to load the probe index, a registered memory
// read and its compare for each slot visited, and a finish step that writes
// the slot and loads the result register. An item visits at most SLOTS
// slots; the finish step is held while the previous result still waits to be
// collected. The next item is taken as soon as the result sits in the output
// register, even if it has not been collected yet.
module linear_probe_hash_table_core import lph_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [30:0] key
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [3:0] slot
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  ctrl_word_t ctrl;
  flags_t     flags;

  lph_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  lph_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .flags_o         (flags),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probe_hash_table_core. Requests go in as
// stream items and each result is checked against a local model of the table.
// The run covers a directed fill to full, then insert/remove/search mixes with
// random gaps on both sides, a long output hold-off and a clean final stretch.
// ----------------------------------------------------------------------------
module tb;
  import lph_pkg::*;

  localparam int TBL_SLOTS   = SLOTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 64;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    stat_e             status;
    logic [SLOT_W-1:0] slot;
  } table_result_t;

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [31:0] s_data;   // [30:0] key
  logic [1:0]  s_user;   // [1:0] req_type
  logic        m_valid;
  logic        m_ready;
  logic [7:0]  m_data;   // [3:0] slot
  logic [2:0]  m_user;   // [2:0] status

  // shadow copy of the table
  logic              tbl_valid [TBL_SLOTS];
  logic [KEY_W-1:0]  tbl_key   [TBL_SLOTS];

  table_result_t expected_results [$];

  int  error_count;
  int  items_sent;
  int  results_checked;
  int  status_hits [5];
  int  cycle_count;
  bit  tx_idle_en;
  bit  rx_stall_en;
  int  rx_hold_cycles;

  linear_probe_hash_table_core #(
    .SLOTS (TBL_SLOTS)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, expected_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Apply one request to the shadow table and return what the block must say.
  function automatic table_result_t table_apply(input logic [REQ_W-1:0] req,
                                                input logic [KEY_W-1:0] key);
    table_result_t res;
    int            idx;
    int            n;
    bit            done;
    res.status = STAT_NOT_FOUND;
    res.slot   = '0;
    idx        = int'(key % TBL_SLOTS);
    done       = 1'b0;
    case (req)
      REQ_INSERT: begin
        res.status = STAT_FULL;
        for (n = 0; n < TBL_SLOTS && !done; n++) begin
          if (!tbl_valid[idx]) begin
            tbl_valid[idx] = 1'b1;
            tbl_key[idx]   = key;
            res.status     = STAT_INSERTED;
            res.slot       = idx[SLOT_W-1:0];
            done           = 1'b1;
          end else begin
            idx = (idx + 1) % TBL_SLOTS;
          end
        end
      end
      REQ_REMOVE, REQ_SEARCH: begin
        for (n = 0; n < TBL_SLOTS && !done; n++) begin
          if (!tbl_valid[idx]) begin
            done = 1'b1;
          end else if (tbl_key[idx] == key) begin
            if (req == REQ_REMOVE) begin
              tbl_valid[idx] = 1'b0;
              res.status     = STAT_REMOVED;
            end else begin
              res.status = STAT_FOUND;
            end
            res.slot = idx[SLOT_W-1:0];
            done     = 1'b1;
          end else begin
            idx = (idx + 1) % TBL_SLOTS;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0:       rand_key = r[KEY_W-1:0];
      1:       rand_key = KEY_W'($urandom_range(0, 63));
      // crowd the last home slots so probes wrap to slot 0
      2:       rand_key = {r[KEY_W-1:4], 4'd12 + 4'($urandom_range(0, 3))};
      default: rand_key = {r[KEY_W-1:4], 4'($urandom_range(0, 2))};
    endcase
  endfunction

  // predict at the edge where the item is taken
  always @(posedge clk) begin
    if (rst_n && s_valid && s_ready)
      expected_results.push_back(table_apply(s_user, s_data[KEY_W-1:0]));
  end

  always @(posedge clk) begin
    table_result_t exp_res;
    if (rst_n && m_valid && m_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d data %0h",
                 $time, m_user, m_data);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (m_user < 3'd5)
          status_hits[m_user]++;
        if (m_user !== exp_res.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, exp_res.status, m_user);
          error_count++;
        end
        if (m_data !== {4'b0000, exp_res.slot}) begin
          $display("%0t: slot mismatch, expected %0h, actual %0h",
                   $time, {4'b0000, exp_res.slot}, m_data);
          error_count++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        m_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_ready <= 1'b1;
    end
  end

  // Offer one item and hold it until taken; valid stays high for the next one.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, key};
    s_user  <= req;
    do @(posedge clk); while (!s_ready);
    items_sent++;
  endtask

  // step past the accepting edge first so the last prediction is queued
  task automatic wait_results_drained();
    s_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_directed();
    int k;
    // fill: home 15 twice (second wraps to slot 0), key 0 twice (duplicate)
    send_item(REQ_INSERT, KEY_W'(15));
    send_item(REQ_INSERT, 31'h7FFF_FFFF);
    send_item(REQ_INSERT, 31'h0000_0000);
    send_item(REQ_INSERT, 31'h0000_0000);
    for (k = 3; k < TBL_SLOTS; k++)
      send_item(REQ_INSERT, KEY_W'(k));
    // table is now full
    send_item(REQ_INSERT, KEY_W'(100));
    send_item(REQ_SEARCH, 31'h5555_5555);
    send_item(REQ_REMOVE, 31'h2AAA_AAAA);
    send_item(REQ_UNUSED, 31'h7FFF_FFFF);
    send_item(REQ_SEARCH, 31'h7FFF_FFFF);
    // removing the first copy leaves a hole that hides the second
    send_item(REQ_REMOVE, 31'h0000_0000);
    send_item(REQ_SEARCH, 31'h0000_0000);
  endtask

  task automatic test_random_mix(input int n_items, input int insert_pct);
    int               i;
    int               j;
    int               pick;
    int               idx;
    bit               got;
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < insert_pct)
        req = REQ_INSERT;
      else if (pick < 96)
        req = $urandom_range(0, 1) ? REQ_REMOVE : REQ_SEARCH;
      else
        req = REQ_UNUSED;
      key = rand_key();
      // mostly look up keys that are stored
      if (req != REQ_INSERT && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, TBL_SLOTS - 1);
        got = 1'b0;
        for (j = 0; j < TBL_SLOTS && !got; j++) begin
          if (tbl_valid[(idx + j) % TBL_SLOTS]) begin
            key = tbl_key[(idx + j) % TBL_SLOTS];
            got = 1'b1;
          end
        end
      end
      send_item(req, key);
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    rx_hold_cycles = 400;
    for (i = 0; i < 12; i++)
      send_item($urandom_range(0, 1) ? REQ_INSERT : REQ_SEARCH, rand_key());
    wait_results_drained();
  endtask

  initial begin
    int k;
    s_valid <= 1'b0;
    s_data  <= '0;
    s_user  <= '0;
    m_ready <= 1'b0;
    rst_n   <= 1'b0;
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    rx_hold_cycles  = 0;
    tx_idle_en      = 1'b0;
    rx_stall_en     = 1'b0;
    for (k = 0; k < 5; k++)
      status_hits[k] = 0;
    for (k = 0; k < TBL_SLOTS; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_key[k]   = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    test_random_mix(400, 55);
    test_random_mix(300, 20);
    wait_results_drained();
    test_output_backpressure();
    tx_idle_en = 1'b0;
    test_random_mix(300, 45);
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b0;
    test_random_mix(300, 35);
    // clean stretch, no gaps on either side
    tx_idle_en = 1'b0;
    test_random_mix(200, 40);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: results missing, expected 0 outstanding, actual %0d",
               $time, expected_results.size());
      error_count++;
    end
    $display("run: %0d items sent, %0d results checked", items_sent, results_checked);
    $display("mix: inserted %0d, full %0d, removed %0d, found %0d, not found %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4]);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== linear_probe_hash_table_core.f =====
rtl/lph_pkg.sv
rtl/lph_sequencer.sv
rtl/lph_datapath.sv
rtl/linear_probe_hash_table_core.sv
test/tb.sv
